/* design/bfa_pkg.sv */
// bfa_pkg: constants, types and command codes for the bitmap frame allocator.
// No dependencies.
package bfa_pkg;
	localparam int TOTAL_FRAMES = 16384;
	localparam int PAGE_BYTES = 4096;
	localparam int WORD_BITS = 32;
	localparam int NUM_WORDS = (TOTAL_FRAMES + WORD_BITS - 1) / WORD_BITS;
	localparam int WADDR_W = $clog2(NUM_WORDS);
	localparam int BIT_W = $clog2(WORD_BITS);
	localparam int FRAME_W = $clog2(TOTAL_FRAMES) + 1;
	localparam int PAGE_SH = $clog2(PAGE_BYTES);
	localparam int CNT_W = 15;
	localparam int ADDR_W = 32;

	typedef enum logic [1:0] {
		CMD_ALLOC = 2'd0,
		CMD_FREE = 2'd1,
		CMD_RESERVE = 2'd2,
		CMD_FREE_REGION = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_READ,
		ST_WAIT,
		ST_MODIFY,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic status;
		logic [ADDR_W-1:0] frame_address;
		logic [CNT_W-1:0] used_count;
		logic [CNT_W-1:0] free_count;
	} result_t;
endpackage

/* design/bfa_if.sv */
// bfa_if: valid/ready channel interface carrying a payload of type T.
// Depends on nothing.
interface bfa_if #(parameter type T = logic) (input logic clk);
	logic valid;
	logic ready;
	T payload;
	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

/* design/bitmap_frame_allocator.sv */
// bitmap_frame_allocator: top level, bitmap memory and command sequencer.
// Depends on bfa_pkg and bfa_if.
//
// Channel  Dir  Payload
// cmd_in   in   command[1:0], address[31:0], byte_count[31:0]
// res_out  out  status, frame_address[31:0], used_count[14:0], free_count[14:0]
//
// Reset sets every bitmap word to all ones with a clearing pass over all NUM_WORDS
// (512) words; no command is taken meanwhile.
// Each command walks the bitmap one word at a time through the states READ, WAIT
// (memory latency) and MODIFY (modify/write); state DONE then presents the result register.
// Free-frame takes one word; a region takes each 32-frame word it touches;
// allocate scans from word 0 until a free bit or the last word.
// The result sits in an output register; a stalled output holds the sequencer.
module bitmap_frame_allocator
	import bfa_pkg::*;
(
	input logic clk,
	input logic arst_n,
	bfa_if.sink cmd_in,
	bfa_if.source res_out
);
	state_t state_q, state_d;
	logic [WORD_BITS-1:0] mem [NUM_WORDS];
	logic [WORD_BITS-1:0] rdata_q;
	logic [WADDR_W:0] waddr_q;
	logic [1:0] cmd_q;
	logic [FRAME_W-1:0] first_q, last_q; // inclusive range, clipped
	logic empty_q;
	logic [CNT_W:0] used_q;
	logic status_q;
	logic [ADDR_W-1:0] faddr_q;
	logic out_valid_q;

	// command decode
	logic [ADDR_W-PAGE_SH-1:0] a_frame;
	logic [ADDR_W:0] len_up;
	logic [ADDR_W-PAGE_SH:0] n_frames;
	logic [ADDR_W-PAGE_SH+1:0] end_x;
	always_comb begin
		a_frame = cmd_in.payload.address[ADDR_W-1:PAGE_SH];
		len_up = {1'b0, cmd_in.payload.byte_count} + (ADDR_W+1)'(PAGE_BYTES - 1);
		if (cmd_in.payload.command == CMD_RESERVE)
			n_frames = len_up[ADDR_W:PAGE_SH];
		else if (cmd_in.payload.command == CMD_FREE_REGION)
			n_frames = {1'b0, cmd_in.payload.byte_count[ADDR_W-1:PAGE_SH]};
		else
			n_frames = (ADDR_W-PAGE_SH+1)'(1);
		end_x = {2'b0, a_frame} + {1'b0, n_frames};
		if (end_x > (ADDR_W-PAGE_SH+2)'(TOTAL_FRAMES))
			end_x = (ADDR_W-PAGE_SH+2)'(TOTAL_FRAMES);
	end

	// word modify
	logic [WORD_BITS-1:0] mask, wnew;
	logic [FRAME_W-1:0] base;
	logic [BIT_W:0] delta;
	logic found;
	logic [BIT_W-1:0] fbit;
	always_comb begin
		base = FRAME_W'({waddr_q[WADDR_W-1:0], {BIT_W{1'b0}}});
		found = 1'b0;
		fbit = '0;
		mask = '0;
		for (int i = 0; i < WORD_BITS; i++) begin
			if (cmd_q == CMD_ALLOC) begin
				if (!found && !rdata_q[i] && (base + FRAME_W'(i)) < FRAME_W'(TOTAL_FRAMES)) begin
					found = 1'b1;
					fbit = BIT_W'(i);
				end
			end else if (!empty_q && (base + FRAME_W'(i)) >= first_q
				&& (base + FRAME_W'(i)) <= last_q) begin
				mask[i] = 1'b1;
			end
		end
		if (cmd_q == CMD_ALLOC && found) mask[fbit] = 1'b1;
		if (cmd_q == CMD_ALLOC || cmd_q == CMD_RESERVE) wnew = rdata_q | mask;
		else wnew = rdata_q & ~mask;
		delta = (BIT_W+1)'($countones(rdata_q ^ wnew));
	end

	logic last_word;
	assign last_word = (cmd_q == CMD_ALLOC) ? (found || waddr_q == (WADDR_W+1)'(NUM_WORDS - 1))
		: (empty_q || waddr_q == (WADDR_W+1)'(last_q[FRAME_W-1:BIT_W]));

	always_ff @(posedge clk) begin
		if (state_q == ST_CLEAR) mem[waddr_q[WADDR_W-1:0]] <= '1;
		else if (state_q == ST_MODIFY && !empty_q) mem[waddr_q[WADDR_W-1:0]] <= wnew;
		rdata_q <= mem[waddr_q[WADDR_W-1:0]];
	end

	assign cmd_in.ready = (state_q == ST_IDLE) && !out_valid_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: if (waddr_q == (WADDR_W+1)'(NUM_WORDS - 1)) state_d = ST_IDLE;
			ST_IDLE: if (cmd_in.valid && cmd_in.ready) state_d = ST_READ;
			ST_READ: state_d = ST_WAIT;
			ST_WAIT: state_d = ST_MODIFY;
			ST_MODIFY: state_d = last_word ? ST_DONE : ST_READ;
			ST_DONE: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			waddr_q <= '0;
			used_q <= (CNT_W+1)'(TOTAL_FRAMES);
			out_valid_q <= 1'b0;
			cmd_q <= '0;
			first_q <= '0;
			last_q <= '0;
			empty_q <= 1'b1;
			status_q <= 1'b0;
			faddr_q <= '0;
		end else begin
			state_q <= state_d;
			if (res_out.valid && res_out.ready) out_valid_q <= 1'b0;
			unique case (state_q)
				ST_CLEAR: waddr_q <= waddr_q + 1'b1;
				ST_IDLE: if (cmd_in.valid && cmd_in.ready) begin
					cmd_q <= cmd_in.payload.command;
					status_q <= 1'b0;
					faddr_q <= '0;
					first_q <= FRAME_W'(a_frame);
					last_q <= FRAME_W'(end_x - 1'b1);
					empty_q <= (cmd_in.payload.command != CMD_ALLOC)
						&& (end_x <= {2'b0, a_frame});
					if (cmd_in.payload.command == CMD_ALLOC) waddr_q <= '0;
					else waddr_q <= {1'b0, a_frame[WADDR_W+BIT_W-1:BIT_W]};
				end
				ST_MODIFY: begin
					if (cmd_q == CMD_ALLOC || cmd_q == CMD_RESERVE)
						used_q <= used_q + (CNT_W+1)'(delta);
					else used_q <= used_q - (CNT_W+1)'(delta);
					if (cmd_q == CMD_ALLOC && found)
						faddr_q <= ADDR_W'({base + FRAME_W'(fbit), {PAGE_SH{1'b0}}});
					if (cmd_q == CMD_ALLOC && !found && last_word) status_q <= 1'b1;
					waddr_q <= waddr_q + 1'b1;
				end
				ST_DONE: out_valid_q <= 1'b1;
				default: ;
			endcase
		end
	end

	assign res_out.valid = out_valid_q;
	assign res_out.payload.status = status_q;
	assign res_out.payload.frame_address = faddr_q;
	assign res_out.payload.used_count = used_q[CNT_W-1:0];
	assign res_out.payload.free_count = CNT_W'((CNT_W+1)'(TOTAL_FRAMES) - used_q);

`ifndef SYNTHESIS
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= (CNT_W+1)'(TOTAL_FRAMES)) else $error("used count overflow");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_in.valid && cmd_in.ready) |=> !cmd_in.ready) else $error("accept while busy");
	a_fail: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && status_q) |-> faddr_q == '0) else $error("fail with address");
`endif
endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps
// tb_top: self-checking testbench for bitmap_frame_allocator.
// Uses bfa_pkg and bfa_if. A bit-level shadow of the frame map predicts every
// result; a queue-fed driver and a clocked monitor run the valid/ready channels.
module tb_top;
	import bfa_pkg::*;

	// Command payload as the block expects it: command, address, byte_count.
	typedef struct packed {
		cmd_t command;
		logic [31:0] address;
		logic [31:0] byte_count;
	} cmd_item_t;

	localparam int STALL_LIMIT = 40000;
	localparam int RANDOM_ITEMS = 1100;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	bfa_if #(.T(cmd_item_t)) cmd_if (clk);
	bfa_if #(.T(result_t)) res_if (clk);

	bitmap_frame_allocator DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_in(cmd_if.sink),
		.res_out(res_if.source)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Shadow state: one bit per frame plus the used count.
	logic frame_map [TOTAL_FRAMES];
	int used_frames;

	cmd_item_t pending_cmds[$];
	result_t expected_results[$];
	int mismatches = 0;
	int sent_count = 0;
	int phase = 0;		// 0 none, 1 sender idles, 2 receiver stalls, 3 both
	int quiet_cycles = 0;

	// Set at the rising edge when the command transfer happened.
	bit last_cmd_transfer = 1'b0;

	// Applies one command to the shadow map and returns the result it yields.
	function automatic result_t apply_command(cmd_item_t it);
		result_t r;
		logic [63:0] first;
		logic [63:0] span;
		logic [63:0] stop;
		int found;
		bit mark;
		r = '0;
		first = {32'd0, it.address} / PAGE_BYTES;
		case (it.command)
			CMD_ALLOC: begin
				found = -1;
				for (int i = 0; i < TOTAL_FRAMES; i++) begin
					if (!frame_map[i]) begin
						found = i;
						break;
					end
				end
				if (found < 0) begin
					r.status = 1'b1;
				end else begin
					frame_map[found] = 1'b1;
					used_frames++;
					r.frame_address = 32'(found * PAGE_BYTES);
				end
			end
			CMD_FREE: begin
				if (first < TOTAL_FRAMES && frame_map[first]) begin
					frame_map[first] = 1'b0;
					used_frames--;
				end
			end
			default: begin
				// reserve rounds the length up, free-region rounds it down
				mark = (it.command == CMD_RESERVE);
				span = mark ? ({32'd0, it.byte_count} + PAGE_BYTES - 1) / PAGE_BYTES
					: {32'd0, it.byte_count} / PAGE_BYTES;
				stop = first + span;
				if (stop > TOTAL_FRAMES)
					stop = TOTAL_FRAMES;
				for (logic [63:0] f = first; f < stop; f++) begin
					if (frame_map[f] != mark) begin
						frame_map[f] = mark;
						used_frames += mark ? 1 : -1;
					end
				end
			end
		endcase
		r.used_count = CNT_W'(used_frames);
		r.free_count = CNT_W'(TOTAL_FRAMES - used_frames);
		return r;
	endfunction

	function automatic cmd_item_t make_cmd(cmd_t c, logic [31:0] a, logic [31:0] n);
		cmd_item_t it;
		it.command = c;
		it.address = a;
		it.byte_count = n;
		return it;
	endfunction

	// Random command: mostly small regions in the low frames so allocate scans
	// stay short; a few fully random items exercise every field bit.
	function automatic cmd_item_t random_cmd();
		int pick;
		logic [31:0] a;
		logic [31:0] n;
		pick = $urandom_range(99);
		a = ($urandom_range(1023) * PAGE_BYTES) | $urandom_range(PAGE_BYTES - 1);
		n = $urandom_range(40 * PAGE_BYTES);
		if (pick < 35)
			return make_cmd(CMD_ALLOC, $urandom, $urandom);
		else if (pick < 60)
			return make_cmd(CMD_FREE, a, $urandom);
		else if (pick < 78)
			return make_cmd(CMD_RESERVE, a, n);
		else if (pick < 95)
			return make_cmd(CMD_FREE_REGION, a, n);
		else
			return make_cmd(cmd_t'($urandom_range(3)), $urandom, $urandom);
	endfunction

	initial begin
		cmd_if.valid = 1'b0;
		cmd_if.payload = '0;
		res_if.ready = 1'b0;
		for (int i = 0; i < TOTAL_FRAMES; i++)
			frame_map[i] = 1'b1;
		used_frames = TOTAL_FRAMES;
	end

	// Driver: hold an item until its transfer, then maybe idle, then the next.
	always @(negedge clk) begin
		if (!cmd_if.valid || last_cmd_transfer) begin
			if (pending_cmds.size() > 0 && !((phase == 1 || phase == 3)
				&& $urandom_range(99) < (phase == 1 ? 45 : 14))) begin
				cmd_if.valid <= 1'b1;
				cmd_if.payload <= pending_cmds.pop_front();
			end else begin
				cmd_if.valid <= 1'b0;
			end
		end
		res_if.ready <= !((phase == 2 || phase == 3)
			&& $urandom_range(99) < (phase == 2 ? 45 : 14));
	end

	// Monitor: predict on each command transfer, check each result transfer.
	always @(posedge clk) begin
		last_cmd_transfer = 1'b0;
		if (arst_n && cmd_if.valid && cmd_if.ready) begin
			last_cmd_transfer = 1'b1;
			expected_results.push_back(apply_command(cmd_if.payload));
			sent_count++;
			if (sent_count > 25)
				phase = ((sent_count - 25) * 4 / RANDOM_ITEMS) % 4;
		end
		if (arst_n && res_if.valid && res_if.ready) begin
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result %p", res_if.payload);
			end else if (res_if.payload !== expected_results[0]) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: expected %p got %p",
						expected_results[0], res_if.payload);
				void'(expected_results.pop_front());
			end else begin
				void'(expected_results.pop_front());
			end
		end
		// watchdog on cycles without any transfer
		if ((cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: reset leaves every frame used, so allocate is out of memory
		pending_cmds.push_back(make_cmd(CMD_ALLOC, 32'h0, 32'h0));
		pending_cmds.push_back(make_cmd(CMD_FREE_REGION, 32'h0, 32'h0));
		pending_cmds.push_back(make_cmd(CMD_FREE_REGION, 32'h0, 32'd4095));
		pending_cmds.push_back(make_cmd(CMD_FREE_REGION, 32'h0, 32'd4096));
		pending_cmds.push_back(make_cmd(CMD_ALLOC, 32'hFFFFFFFF, 32'hFFFFFFFF));
		pending_cmds.push_back(make_cmd(CMD_ALLOC, 32'h0, 32'h0));
		pending_cmds.push_back(make_cmd(CMD_FREE, 32'hFFFFFFFF, 32'h0));
		pending_cmds.push_back(make_cmd(CMD_RESERVE, 32'hFFFFF000, 32'hFFFFFFFF));
		pending_cmds.push_back(make_cmd(CMD_FREE_REGION, 32'h0, 32'hFFFFFFFF));
		pending_cmds.push_back(make_cmd(CMD_ALLOC, 32'h0, 32'h0));
		pending_cmds.push_back(make_cmd(CMD_RESERVE, 32'h1000, 32'd1));
		pending_cmds.push_back(make_cmd(CMD_RESERVE, 32'h1FFF, 32'd2));
		pending_cmds.push_back(make_cmd(CMD_ALLOC, 32'h0, 32'h0));
		pending_cmds.push_back(make_cmd(CMD_FREE, 32'h00000FFF, 32'h0));
		pending_cmds.push_back(make_cmd(CMD_ALLOC, 32'h0, 32'h0));
		pending_cmds.push_back(make_cmd(CMD_RESERVE, 32'h0, 32'hFFFFFFFF));
		pending_cmds.push_back(make_cmd(CMD_ALLOC, 32'h0, 32'h0));
		pending_cmds.push_back(make_cmd(CMD_FREE_REGION, 32'(16380 * PAGE_BYTES),
			32'hFFFFFFFF));
		pending_cmds.push_back(make_cmd(CMD_ALLOC, 32'h0, 32'h0));
		pending_cmds.push_back(make_cmd(CMD_FREE, 32'(16383 * PAGE_BYTES), 32'h0));
		pending_cmds.push_back(make_cmd(CMD_FREE, 32'(16384 * PAGE_BYTES), 32'h0));
		pending_cmds.push_back(make_cmd(CMD_FREE_REGION, 32'h0, 32'(64 * PAGE_BYTES)));
		pending_cmds.push_back(make_cmd(CMD_ALLOC, 32'h0, 32'h0));

		// pause the sender until everything issued so far has come back
		wait (pending_cmds.size() == 0 && !cmd_if.valid && expected_results.size() == 0);
		repeat (20) @(posedge clk);
		for (int i = 0; i < RANDOM_ITEMS; i++)
			pending_cmds.push_back(random_cmd());

		wait (pending_cmds.size() == 0 && !cmd_if.valid && expected_results.size() == 0);
		repeat (2000) @(posedge clk);
		if (mismatches == 0 && expected_results.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end
endmodule
